// ----- sv/sbr_pkg.sv -----
// Shared types and constants of the saturating ratio scaler.
package sbr_pkg;

    localparam int MagW   = 64;
    localparam int HalfW  = 32;
    localparam int ProdW  = 96;
    localparam int CfgIdxW = 2;

    localparam logic [MagW-1:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [MagW-1:0] NEG_MIN = 64'h8000_0000_0000_0000;

    localparam logic [CfgIdxW-1:0] REG_RATIO_NUM = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_RATIO_DEN = 2'd1;

    // One item inside the divider: partial remainder, and a shift register
    // that gives up dividend bits at the top and takes quotient bits at the bottom.
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             sat;
        logic [HalfW-1:0] rem;
        logic [MagW-1:0]  bits;
    } t_div;

endpackage

// ----- sv/scale_by_ratio_saturating_top.sv -----
// Top level of the saturating ratio scaler: config registers, pipeline and flow control.
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+--------------------------------------
//  input    | i_valid | o_stall | i_sample_in  (signed 64)
//  output   | o_valid | i_stall | o_scaled_out (signed 64)
//  config   | i_cfg_we| -       | i_cfg_index (2), i_cfg_data (32)
//
// One item per cycle sustained while the output is not stalled; an item passes
// 64/STEPS_PER_STAGE + 4 register stages (20 with the default): the front
// stages, the divider pipeline, which resolves STEPS_PER_STAGE quotient bits
// in each stage, and the output register.
// Reset is synchronous, active low: it empties every stage and sets the
// ratio to 1/1.
// A stall on the output only reaches o_stall once every stage holds an
// item; bubbles are squeezed out while the output waits.
module scale_by_ratio_saturating_top #(
    parameter int STEPS_PER_STAGE = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sbr_pkg::MagW-1:0]       i_sample_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sbr_pkg::MagW-1:0]       o_scaled_out,
    input  logic                           i_cfg_we,
    input  logic [sbr_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [sbr_pkg::HalfW-1:0]      i_cfg_data
);

    // Three front stages, the divider stages, then the output register.
    localparam int DivStages = sbr_pkg::MagW / STEPS_PER_STAGE;
    localparam int NumStages = DivStages + 4;

    logic [sbr_pkg::HalfW-1:0]  r_ratio_num;
    logic [sbr_pkg::HalfW-1:0]  r_ratio_den;
    logic [NumStages-1:0]       s_valid;
    logic [NumStages-1:0]       s_en;
    sbr_pkg::t_div              s_div [DivStages+1];

    // Configuration: a zero denominator is dropped, unknown indexes ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_num <= 32'd1;
            r_ratio_den <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbr_pkg::REG_RATIO_NUM: begin
                    r_ratio_num <= i_cfg_data;
                end
                sbr_pkg::REG_RATIO_DEN: begin
                    if (i_cfg_data != '0) r_ratio_den <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or its item moves on downstream.
    always_comb begin
        s_en[NumStages-1] = !s_valid[NumStages-1] || !i_stall;
        for (int k = NumStages - 2; k >= 0; k--) begin
            s_en[k] = !s_valid[k] || s_en[k+1];
        end
    end

    assign o_stall = !s_en[0];

    sbr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s_en[2:0]),
        .i_valid  (i_valid),
        .i_sample (i_sample_in),
        .i_num    (r_ratio_num),
        .i_den    (r_ratio_den),
        .o_valid  (s_valid[2:0]),
        .o_div    (s_div[0])
    );

    for (genvar g = 0; g < DivStages; g++) begin : g_div
        sbr_div_stage #(
            .Steps (STEPS_PER_STAGE)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en[3+g]),
            .i_den   (r_ratio_den),
            .i_div   (s_div[g]),
            .o_div   (s_div[g+1])
        );
        assign s_valid[3+g] = s_div[g+1].valid;
    end

    sbr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en[NumStages-1]),
        .i_div   (s_div[DivStages]),
        .o_valid (s_valid[NumStages-1]),
        .o_data  (o_scaled_out)
    );

    assign o_valid = s_valid[NumStages-1];

`ifndef NO_ASSERTIONS
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ratio_den != '0)
        else $error("ratio denominator became zero");

    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&s_valid) && i_stall) |-> o_stall)
        else $error("full pipeline took an item under output stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> s_valid[0])
        else $error("accepted item did not enter the first stage");
`endif

endmodule

// ----- sv/sbr_front.sv -----
// Front stages: magnitude, partial products and the 96-bit product.
module sbr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [2:0]                 i_en,
    input  logic                       i_valid,
    input  logic [sbr_pkg::MagW-1:0]   i_sample,
    input  logic [sbr_pkg::HalfW-1:0]  i_num,
    input  logic [sbr_pkg::HalfW-1:0]  i_den,
    output logic [2:0]                 o_valid,
    output sbr_pkg::t_div              o_div
);

    logic                        r_v0, r_v1, r_v2;
    logic                        r_neg0, r_neg1, r_neg2;
    logic [sbr_pkg::MagW-1:0]    r_mag0;
    logic [sbr_pkg::MagW-1:0]    r_prod_hi, r_prod_lo;
    logic [sbr_pkg::ProdW-1:0]   r_prod;
    logic [sbr_pkg::MagW-1:0]    n_mag0;
    logic [sbr_pkg::MagW-1:0]    n_prod_hi, n_prod_lo;
    logic [sbr_pkg::ProdW-1:0]   n_prod;

    assign n_mag0    = i_sample[sbr_pkg::MagW-1] ? (64'd0 - i_sample) : i_sample;
    assign n_prod_hi = {{sbr_pkg::HalfW{1'b0}}, i_num}
                     * {{sbr_pkg::HalfW{1'b0}}, r_mag0[sbr_pkg::MagW-1:sbr_pkg::HalfW]};
    assign n_prod_lo = {{sbr_pkg::HalfW{1'b0}}, i_num}
                     * {{sbr_pkg::HalfW{1'b0}}, r_mag0[sbr_pkg::HalfW-1:0]};
    assign n_prod    = {r_prod_hi + {32'd0, r_prod_lo[sbr_pkg::MagW-1:sbr_pkg::HalfW]},
                        r_prod_lo[sbr_pkg::HalfW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_en[0]) r_v0 <= i_valid;
            if (i_en[1]) r_v1 <= r_v0;
            if (i_en[2]) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg0 <= i_sample[sbr_pkg::MagW-1];
            r_mag0 <= n_mag0;
        end
        if (i_en[1]) begin
            r_neg1    <= r_neg0;
            r_prod_hi <= n_prod_hi;
            r_prod_lo <= n_prod_lo;
        end
        if (i_en[2]) begin
            r_neg2 <= r_neg1;
            r_prod <= n_prod;
        end
    end

    assign o_valid = {r_v2, r_v1, r_v0};

    // Quotient reaches 2^63 exactly when the product's top 33 bits reach the divisor.
    always_comb begin
        o_div.valid = r_v2;
        o_div.neg   = r_neg2;
        o_div.sat   = (r_prod[sbr_pkg::ProdW-1:sbr_pkg::MagW-1] >= {1'b0, i_den});
        o_div.rem   = r_prod[sbr_pkg::ProdW-1:sbr_pkg::MagW];
        o_div.bits  = r_prod[sbr_pkg::MagW-1:0];
    end

endmodule

// ----- sv/sbr_div_stage.sv -----
// One stage of the restoring divider: it resolves Steps quotient bits.
module sbr_div_stage #(
    parameter int Steps = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [sbr_pkg::HalfW-1:0]  i_den,
    input  sbr_pkg::t_div              i_div,
    output sbr_pkg::t_div              o_div
);

    logic                        r_valid;
    sbr_pkg::t_div               r_div;
    sbr_pkg::t_div               n_div;
    logic [sbr_pkg::HalfW:0]     s_trial;
    logic                        s_q;

    always_comb begin
        n_div   = i_div;
        s_trial = '0;
        s_q     = 1'b0;
        for (int k = 0; k < Steps; k++) begin
            s_trial = {n_div.rem, n_div.bits[sbr_pkg::MagW-1]};
            s_q     = (s_trial >= {1'b0, i_den});
            if (s_q) begin
                n_div.rem = sbr_pkg::HalfW'(s_trial - {1'b0, i_den});
            end else begin
                n_div.rem = s_trial[sbr_pkg::HalfW-1:0];
            end
            n_div.bits = {n_div.bits[sbr_pkg::MagW-2:0], s_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    always_comb begin
        o_div       = r_div;
        o_div.valid = r_valid;
    end

endmodule

// ----- sv/sbr_out.sv -----
// Output stage: sign restore, rounding toward minus infinity and saturation.
module sbr_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  sbr_pkg::t_div             i_div,
    output logic                      o_valid,
    output logic [sbr_pkg::MagW-1:0]  o_data
);

    logic                        r_valid;
    logic                        r_neg;
    logic [sbr_pkg::MagW-1:0]    r_data;
    logic [sbr_pkg::MagW-1:0]    n_data;

    // Negative: -(q+1) is ~q when a remainder is left, else -q.
    always_comb begin
        if (!i_div.neg) begin
            n_data = i_div.sat ? sbr_pkg::POS_MAX : i_div.bits;
        end else if (i_div.sat) begin
            n_data = sbr_pkg::NEG_MIN;
        end else if (i_div.rem != '0) begin
            n_data = ~i_div.bits;
        end else begin
            n_data = 64'd0 - i_div.bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= i_div.neg;
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef NO_ASSERTIONS
    a_pos_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_neg) |-> !r_data[sbr_pkg::MagW-1])
        else $error("non-negative sample gave a negative result");

    a_neg_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_neg) |-> (r_data[sbr_pkg::MagW-1] || r_data == '0))
        else $error("negative sample gave a positive result");
`endif

endmodule
